[sv/scbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types, codes and helpers of the shape command byte parser.
// ----------------------------------------------------------------------------
package scbp_pkg;

    localparam int LETTER_COUNT    = 26;
    localparam int VALUE_BITS      = 32;
    localparam int LETTER_IDX_BITS = $clog2(LETTER_COUNT);
    localparam int BASE_BITS       = 16;
    localparam int OUT_BITS        = 4 + 10 * 32 + 3;
    localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] QUOTE_BYTE = 8'd34;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_LZ      = 8'h7a;
    localparam logic [7:0] CMD_CLEAR  = 8'h5a; // Z
    localparam logic [7:0] CMD_RECT   = 8'h52; // R
    localparam logic [7:0] CMD_CIRCLE = 8'h4f; // O
    localparam logic [7:0] CMD_POINT  = 8'h50; // P
    localparam logic [7:0] CMD_POLY   = 8'h4c; // L
    localparam logic [7:0] CMD_RADIX  = 8'h23; // #
    localparam logic [7:0] CMD_COLOUR = 8'h43; // C
    localparam logic [7:0] CMD_TEXT   = 8'h54; // T
    localparam logic [7:0] CMD_SERIES = 8'h2c; // ,
    localparam logic [7:0] CMD_GRAPH  = 8'h47; // G
    localparam logic [7:0] CMD_QUERY  = 8'h3f; // ?

    localparam logic [BASE_BITS-1:0] DEC_BASE = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] HEX_BASE = BASE_BITS'(16);
    localparam logic [VALUE_BITS-1:0] DISPLAY_TURN = VALUE_BITS'(1);

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_CLEAR     = 4'd1;
    localparam logic [3:0] EV_RECT      = 4'd2;
    localparam logic [3:0] EV_CIRCLE    = 4'd3;
    localparam logic [3:0] EV_POINT     = 4'd4;
    localparam logic [3:0] EV_POLYGON   = 4'd5;
    localparam logic [3:0] EV_TEXT      = 4'd6;
    localparam logic [3:0] EV_SERIES    = 4'd7;
    localparam logic [3:0] EV_GRAPH     = 4'd8;
    localparam logic [3:0] EV_TEXTSTART = 4'd9;
    localparam logic [3:0] EV_TEXTCHAR  = 4'd10;
    localparam logic [3:0] EV_QUERY     = 4'd11;

    localparam logic [LETTER_IDX_BITS-1:0] L_C = LETTER_IDX_BITS'(2);
    localparam logic [LETTER_IDX_BITS-1:0] L_D = LETTER_IDX_BITS'(3);
    localparam logic [LETTER_IDX_BITS-1:0] L_F = LETTER_IDX_BITS'(5);
    localparam logic [LETTER_IDX_BITS-1:0] L_H = LETTER_IDX_BITS'(7);
    localparam logic [LETTER_IDX_BITS-1:0] L_I = LETTER_IDX_BITS'(8);
    localparam logic [LETTER_IDX_BITS-1:0] L_S = LETTER_IDX_BITS'(18);
    localparam logic [LETTER_IDX_BITS-1:0] L_W = LETTER_IDX_BITS'(22);
    localparam logic [LETTER_IDX_BITS-1:0] L_X = LETTER_IDX_BITS'(23);
    localparam logic [LETTER_IDX_BITS-1:0] L_Y = LETTER_IDX_BITS'(24);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef value_t [LETTER_COUNT-1:0] letters_t;

    typedef struct packed {
        logic                       clear;
        logic                       wr_en;
        logic [LETTER_IDX_BITS-1:0] wr_idx;
        value_t                     wr_data;
    } attr_wr_t;

    typedef struct packed {
        logic [2:0]  direction;
        logic [31:0] size;
        logic [31:0] font;
        logic [31:0] value;
        logic [31:0] group_id;
        logic [31:0] color;
        logic [31:0] diameter;
        logic [31:0] height;
        logic [31:0] width;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [3:0]  event_res;
    } result_t;

    // sign-extend or cut a stored value to a 32-bit field
    function automatic logic [31:0] field32(input value_t v);
        return 32'(signed'(v));
    endfunction

    function automatic logic [31:0] short16(input value_t v);
        return 32'(signed'(v[15:0]));
    endfunction

endpackage
`default_nettype wire

[sv/scbp_attr_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_attr_regs
// The 26 letter attribute registers: one write port, clear-all on command.
// ----------------------------------------------------------------------------
module scbp_attr_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scbp_pkg::attr_wr_t wr,
    output scbp_pkg::letters_t     letters
);
    import scbp_pkg::*;

    letters_t letters_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letters_reg <= '0;
        end
        else if (wr.clear)
        begin
            letters_reg <= '0;
        end
        else if (wr.wr_en)
        begin
            letters_reg[wr.wr_idx] <= wr.wr_data;
        end
    end

    assign letters = letters_reg;

endmodule
`default_nettype wire

[sv/scbp_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_decoder
// Decodes one command byte against the parser state: result, next state and
// attribute write.
// ----------------------------------------------------------------------------
module scbp_decoder (
    input  wire logic [7:0]                     in_byte,
    input  wire scbp_pkg::value_t               acc,
    input  wire logic [scbp_pkg::BASE_BITS-1:0] base,
    input  wire logic [7:0]                     last_byte,
    input  wire logic                           in_quote,
    input  wire scbp_pkg::letters_t             letters,
    output scbp_pkg::result_t                   res,
    output scbp_pkg::value_t                    acc_next,
    output logic [scbp_pkg::BASE_BITS-1:0]      base_next,
    output logic                                quote_next,
    output scbp_pkg::attr_wr_t                  attr_wr
);
    import scbp_pkg::*;

    logic                            is_digit;
    logic [3:0]                      digit;
    logic [VALUE_BITS+BASE_BITS-1:0] prod;
    value_t                          turn;
    value_t                          size_p1;

    always_comb
    begin
        is_digit = ((in_byte >= CH_0) && (in_byte <= CH_9)) ||
                   ((base > DEC_BASE) && (in_byte >= CH_LA) && (in_byte <= CH_LF));
        digit    = (in_byte <= CH_9) ? 4'(in_byte - CH_0) : 4'(in_byte - CH_LA + 8'd10);
        prod     = (VALUE_BITS + BASE_BITS)'(acc) * (VALUE_BITS + BASE_BITS)'(base);
        turn     = letters[L_D] + DISPLAY_TURN;
        size_p1  = letters[L_S] + VALUE_BITS'(1);

        res        = '0;
        acc_next   = acc;
        base_next  = base;
        quote_next = in_quote;
        attr_wr    = '0;

        if (in_byte == QUOTE_BYTE)
        begin
            if (last_byte == QUOTE_BYTE)
            begin
                if (in_quote)
                begin
                    res.event_res = EV_TEXTSTART;
                end
                else
                begin
                    // doubled quote outside text: literal quote, text resumes
                    res.event_res = EV_TEXTCHAR;
                    res.value     = 32'(QUOTE_BYTE);
                    quote_next    = 1'b1;
                end
            end
            else if (in_quote)
            begin
                quote_next = 1'b0;
            end
            else
            begin
                quote_next    = 1'b1;
                res.event_res = EV_TEXTSTART;
            end
        end
        else if (in_quote)
        begin
            res.event_res = EV_TEXTCHAR;
            res.value     = 32'(in_byte);
        end
        else if (is_digit)
        begin
            acc_next = VALUE_BITS'(prod) + VALUE_BITS'(digit);
        end
        else if ((in_byte >= CH_LA) && (in_byte <= CH_LZ))
        begin
            attr_wr.wr_en   = 1'b1;
            attr_wr.wr_idx  = LETTER_IDX_BITS'(in_byte - CH_LA);
            attr_wr.wr_data = acc;
            acc_next        = '0;
            base_next       = DEC_BASE;
        end
        else
        begin
            unique case (in_byte)
                CMD_CLEAR:
                begin
                    res.event_res = EV_CLEAR;
                    attr_wr.clear = 1'b1;
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_RECT:
                begin
                    res.event_res = EV_RECT;
                    res.pos_x     = field32(letters[L_X]);
                    res.pos_y     = field32(letters[L_Y]);
                    res.width     = field32(letters[L_W]);
                    res.height    = field32(letters[L_H]);
                    res.color     = field32(letters[L_C]);
                    res.group_id  = field32(letters[L_I]);
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_CIRCLE:
                begin
                    res.event_res = EV_CIRCLE;
                    res.pos_x     = field32(letters[L_X]);
                    res.pos_y     = field32(letters[L_Y]);
                    res.diameter  = field32(letters[L_D]);
                    res.color     = field32(letters[L_C]);
                    res.group_id  = field32(letters[L_I]);
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_POINT:
                begin
                    res.event_res = EV_POINT;
                    res.pos_x     = short16(letters[L_X]);
                    res.pos_y     = short16(letters[L_Y]);
                end
                CMD_POLY:
                begin
                    res.event_res = EV_POLYGON;
                    res.color     = field32(letters[L_C]);
                    res.group_id  = field32(letters[L_I]);
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_RADIX:
                begin
                    base_next = (acc == '0) ? HEX_BASE : BASE_BITS'(acc);
                    acc_next  = '0;
                end
                CMD_COLOUR:
                begin
                    attr_wr.wr_en   = 1'b1;
                    attr_wr.wr_idx  = L_C;
                    attr_wr.wr_data = acc;
                    acc_next        = '0;
                    base_next       = DEC_BASE;
                end
                CMD_TEXT:
                begin
                    res.event_res = EV_TEXT;
                    res.pos_x     = field32(letters[L_X]);
                    res.pos_y     = field32(letters[L_Y]);
                    res.color     = field32(letters[L_C]);
                    res.group_id  = field32(letters[L_I]);
                    res.font      = field32(letters[L_F]);
                    res.size      = field32(size_p1);
                    // remainder by four, sign follows the dividend
                    if (turn[VALUE_BITS-1] && (turn[1:0] != 2'b00))
                        res.direction = {1'b1, turn[1:0]};
                    else
                        res.direction = {1'b0, turn[1:0]};
                end
                CMD_SERIES:
                begin
                    res.event_res = EV_SERIES;
                    res.value     = field32(acc);
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_GRAPH:
                begin
                    res.event_res = EV_GRAPH;
                    res.value     = field32(acc);
                    res.width     = field32(letters[L_W]);
                    acc_next      = '0;
                    base_next     = DEC_BASE;
                end
                CMD_QUERY:
                begin
                    res.event_res = EV_QUERY;
                end
                default:
                begin
                    res.event_res = EV_NONE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/shape_command_byte_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shape_command_byte_parser_unit
// Command byte parser for a shape display: one event result per byte.
// ----------------------------------------------------------------------------
// One result transfer for every input byte, in order. A byte enters an input
// register, and in the cycle it leaves that register the decoder updates the
// accumulator, radix, quote flag and letter registers and loads the result
// register, so the unit sustains one byte per clock while the results are
// taken. A byte waits in the input register while the result register holds
// an untaken result. The single multiply-add of the digit accumulator
// (32 x 16 bits) sits in the decode logic between the two registers. Input is
// taken while a result waits if the input register is empty or can drain.
module shape_command_byte_parser_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // low bit up: event_res[3:0], pos_x, pos_y, width, height, diameter,
    // color, group_id, value, font, size (32 each), direction[2:0], zero pad
    output logic [scbp_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata
);
    import scbp_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    value_t               acc_reg;
    logic [BASE_BITS-1:0] base_reg;
    logic [7:0]           last_byte_reg;
    logic                 quote_reg;

    result_t              res_next;
    value_t               acc_next;
    logic [BASE_BITS-1:0] base_next;
    logic                 quote_next;
    attr_wr_t             attr_wr;
    attr_wr_t             attr_wr_gated;
    letters_t             letters;
    logic                 advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        attr_wr_gated       = attr_wr;
        attr_wr_gated.clear = attr_wr.clear && advance;
        attr_wr_gated.wr_en = attr_wr.wr_en && advance;
    end

    scbp_decoder u_decoder (
        .in_byte    (in_byte_reg),
        .acc        (acc_reg),
        .base       (base_reg),
        .last_byte  (last_byte_reg),
        .in_quote   (quote_reg),
        .letters    (letters),
        .res        (res_next),
        .acc_next   (acc_next),
        .base_next  (base_next),
        .quote_next (quote_next),
        .attr_wr    (attr_wr)
    );

    scbp_attr_regs u_attr_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (attr_wr_gated),
        .letters (letters)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            base_reg      <= DEC_BASE;
            last_byte_reg <= 8'd0;
            quote_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                acc_reg       <= acc_next;
                base_reg      <= base_next;
                last_byte_reg <= in_byte_reg;
                quote_reg     <= quote_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'(out_res_reg);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_result_follows_decode: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("decoded byte produced no result");

    a_event_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_res_reg.event_res <= EV_QUERY))
        else $error("event code out of range");

    a_quote_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && quote_reg && (in_byte_reg == QUOTE_BYTE) &&
         (last_byte_reg != QUOTE_BYTE)) |=> !quote_reg)
        else $error("closing quote did not end text");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(acc_reg) && $stable(base_reg) && $stable(quote_reg)))
        else $error("parser state changed without a byte");

endmodule
`default_nettype wire

[sim/scbp_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_event_checker
// Watches both streams of the command byte parser. Every accepted byte runs
// through a local copy of the parser state and produces the expected event.
// Every result transfer is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module scbp_event_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [scbp_pkg::OUT_TDATA_BITS-1:0] out_data,
    output int                                  mismatch_count,
    output int                                  events_pending
);
    import scbp_pkg::*;

    // local copy of the parser state
    value_t                 number;
    logic [BASE_BITS-1:0]   radix;
    logic [7:0]             prev_byte;
    logic                   quoting;
    value_t                 attrs [LETTER_COUNT];

    result_t                expected_events [$];
    result_t                next_event;
    int                     result_idx;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("scbp checker: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: expected %h, got %h",
                                      result_idx, name, want, got));
    endtask

    task automatic compare_event(input result_t want,
                                 input logic [OUT_TDATA_BITS-1:0] raw);
        result_t got;
        got = result_t'(raw[OUT_BITS-1:0]);
        check_field("event_res", 32'(want.event_res), 32'(got.event_res));
        check_field("pos_x",     want.pos_x,          got.pos_x);
        check_field("pos_y",     want.pos_y,          got.pos_y);
        check_field("width",     want.width,          got.width);
        check_field("height",    want.height,         got.height);
        check_field("diameter",  want.diameter,       got.diameter);
        check_field("color",     want.color,          got.color);
        check_field("group_id",  want.group_id,       got.group_id);
        check_field("value",     want.value,          got.value);
        check_field("font",      want.font,           got.font);
        check_field("size",      want.size,           got.size);
        check_field("direction", 32'(want.direction), 32'(got.direction));
        check_field("pad",       32'd0,               32'(raw[OUT_TDATA_BITS-1:OUT_BITS]));
    endtask

    task automatic restart_number();
        number = '0;
        radix  = DEC_BASE;
    endtask

    // one byte through the parser: updates the local state, returns the event
    task automatic predict_event(input logic [7:0] b, output result_t r);
        value_t              digit;
        logic signed [31:0]  turned;
        r = '0;
        if (b == QUOTE_BYTE) begin
            if (prev_byte == QUOTE_BYTE) begin
                if (quoting) begin
                    r.event_res = EV_TEXTSTART;
                end
                else begin
                    // doubled quote outside text: literal quote, text opens
                    r.event_res = EV_TEXTCHAR;
                    r.value     = 32'(QUOTE_BYTE);
                    quoting     = 1'b1;
                end
            end
            else if (quoting) begin
                quoting = 1'b0;
            end
            else begin
                quoting     = 1'b1;
                r.event_res = EV_TEXTSTART;
            end
        end
        else if (quoting) begin
            r.event_res = EV_TEXTCHAR;
            r.value     = {24'd0, b};
        end
        else if ((b >= CH_0 && b <= CH_9) ||
                 (radix > DEC_BASE && b >= CH_LA && b <= CH_LF)) begin
            digit  = (b <= CH_9) ? value_t'(b - CH_0) : value_t'(b - CH_LA) + value_t'(10);
            number = value_t'(number * value_t'(radix) + digit);
        end
        else if (b >= CH_LA && b <= CH_LZ) begin
            attrs[b - CH_LA] = number;
            restart_number();
        end
        else begin
            case (b)
                CMD_CLEAR: begin
                    r.event_res = EV_CLEAR;
                    for (int k = 0; k < LETTER_COUNT; k++)
                        attrs[k] = '0;
                    restart_number();
                end
                CMD_RECT: begin
                    r.event_res = EV_RECT;
                    r.pos_x     = attrs[L_X];
                    r.pos_y     = attrs[L_Y];
                    r.width     = attrs[L_W];
                    r.height    = attrs[L_H];
                    r.color     = attrs[L_C];
                    r.group_id  = attrs[L_I];
                    restart_number();
                end
                CMD_CIRCLE: begin
                    r.event_res = EV_CIRCLE;
                    r.pos_x     = attrs[L_X];
                    r.pos_y     = attrs[L_Y];
                    r.diameter  = attrs[L_D];
                    r.color     = attrs[L_C];
                    r.group_id  = attrs[L_I];
                    restart_number();
                end
                CMD_POINT: begin
                    // coordinates cut to 16 bits, sign kept
                    r.event_res = EV_POINT;
                    r.pos_x     = {{16{attrs[L_X][15]}}, attrs[L_X][15:0]};
                    r.pos_y     = {{16{attrs[L_Y][15]}}, attrs[L_Y][15:0]};
                end
                CMD_POLY: begin
                    r.event_res = EV_POLYGON;
                    r.color     = attrs[L_C];
                    r.group_id  = attrs[L_I];
                    restart_number();
                end
                CMD_RADIX: begin
                    radix  = (number == '0) ? HEX_BASE : number[BASE_BITS-1:0];
                    number = '0;
                end
                CMD_COLOUR: begin
                    attrs[L_C] = number;
                    restart_number();
                end
                CMD_TEXT: begin
                    // remainder takes the sign of the dividend
                    turned      = signed'(attrs[L_D] + DISPLAY_TURN);
                    r.event_res = EV_TEXT;
                    r.pos_x     = attrs[L_X];
                    r.pos_y     = attrs[L_Y];
                    r.color     = attrs[L_C];
                    r.group_id  = attrs[L_I];
                    r.font      = attrs[L_F];
                    r.size      = attrs[L_S] + 32'd1;
                    r.direction = 3'(turned % 4);
                end
                CMD_SERIES: begin
                    r.event_res = EV_SERIES;
                    r.value     = number;
                    restart_number();
                end
                CMD_GRAPH: begin
                    r.event_res = EV_GRAPH;
                    r.value     = number;
                    r.width     = attrs[L_W];
                    restart_number();
                end
                CMD_QUERY: begin
                    r.event_res = EV_QUERY;
                end
                default: begin
                end
            endcase
        end
        prev_byte = b;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restart_number();
            prev_byte = '0;
            quoting   = 1'b0;
            for (int k = 0; k < LETTER_COUNT; k++)
                attrs[k] = '0;
            expected_events.delete();
            events_pending = 0;
            result_idx     = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_idx));
                else
                    compare_event(expected_events.pop_front(), out_data);
                result_idx++;
            end
            if (in_valid && in_ready) begin
                predict_event(in_byte, next_event);
                expected_events.insert(expected_events.size(), next_event);
            end
            events_pending = expected_events.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream test of the shape command byte parser: a directed opening,
// then well-formed commands with random content mixed with noise, under
// several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import scbp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 256;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;

    int                         mismatch_count;
    int                         events_pending;
    int                         cycle_count = 0;
    int                         sender_idle_pct;
    int                         recv_stall_pct;
    bit                         squeeze_req;
    logic [7:0]                 plan [$];

    shape_command_byte_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    scbp_event_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_byte        (s_axis_tdata),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        bit squeezed;
        hold_left     = 0;
        squeezed      = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic plan_add(input logic [7:0] b);
        plan.insert(plan.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            plan_add(s[k]);
    endtask

    function automatic logic [7:0] pick_terminator();
        logic [LETTER_IDX_BITS-1:0] used_letters [9];
        used_letters = '{L_C, L_D, L_F, L_H, L_I, L_S, L_W, L_X, L_Y};
        case ($urandom_range(10))
            0, 1, 2, 3, 4, 5: return CH_LA + 8'(used_letters[$urandom_range(8)]);
            6:                return CH_LA + 8'($urandom_range(25));
            7:                return CMD_COLOUR;
            8:                return CMD_SERIES;
            9:                return CMD_GRAPH;
            default:          return CMD_RADIX;
        endcase
    endfunction

    // well-formed commands with random content, some noise in between
    task automatic add_random_bytes(input int n);
        int          kind;
        int          len;
        int          dv;
        int          base;
        logic [31:0] num;
        logic [7:0]  ch;
        while (plan.size() < n)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                case ($urandom_range(9))
                    0:       num = 32'd0;
                    1:       num = 32'hFFFF_FFFF;
                    2:       num = 32'h7FFF_FFFF;
                    3:       num = 32'h8000_0000;
                    4:       num = 32'h0000_8000 - $urandom_range(1);
                    5, 6:    num = $urandom_range(999);
                    7:       num = 32'h0000_FFFF + $urandom_range(1);
                    default: num = $urandom;
                endcase
                // an extra run of digits in front can make the accumulator wrap
                if ($urandom_range(4) == 0)
                    add_text($sformatf("%0d", $urandom));
                add_text($sformatf("%0d", num));
                plan_add(pick_terminator());
            end
            else if (kind < 57)
            begin
                case ($urandom_range(9))
                    0:       begin add_text("65536");      base = 0;     end
                    1:       begin add_text("1");          base = 1;     end
                    2:       begin add_text("2");          base = 2;     end
                    3:       begin add_text("8");          base = 8;     end
                    4:       begin add_text("10");         base = 10;    end
                    5:       begin add_text("0");          base = 16;    end
                    6:       begin add_text("36");         base = 36;    end
                    7:       begin add_text("255");        base = 255;   end
                    8:       begin add_text("4294967295"); base = 65535; end
                    default: base = 16;
                endcase
                plan_add(CMD_RADIX);
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    dv = (base > 10) ? $urandom_range(15) : $urandom_range(9);
                    plan_add(dv < 10 ? CH_0 + 8'(dv) : CH_LA + 8'(dv - 10));
                end
                plan_add(pick_terminator());
            end
            else if (kind < 75)
            begin
                case ($urandom_range(7))
                    0:       plan_add(CMD_RECT);
                    1:       plan_add(CMD_CIRCLE);
                    2:       plan_add(CMD_POINT);
                    3:       plan_add(CMD_POLY);
                    4:       plan_add(CMD_TEXT);
                    5:       plan_add(CMD_QUERY);
                    6:       plan_add(CMD_GRAPH);
                    default: plan_add(CMD_SERIES);
                endcase
            end
            else if (kind < 86)
            begin
                plan_add(QUOTE_BYTE);
                len = $urandom_range(8);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(7) == 0)
                    begin
                        plan_add(QUOTE_BYTE);
                        plan_add(QUOTE_BYTE);
                    end
                    else
                    begin
                        ch = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(32, 126));
                        plan_add(ch == QUOTE_BYTE ? CMD_QUERY : ch);
                    end
                end
                plan_add(QUOTE_BYTE);
            end
            else if (kind < 88)
                plan_add(CMD_CLEAR);
            else
            begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    plan_add(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_plan();
        logic [7:0] cur_byte;
        while (plan.size() != 0)
        begin
            cur_byte = plan.pop_front();
            while ($urandom_range(99) < sender_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= cur_byte;
            do
                @(posedge clk);
            while (!s_axis_tready);
        end
    endtask

    initial
    begin : stimulus
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'h00;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        squeeze_req     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        plan_add(8'h00);
        plan_add(8'hFF);
        plan_add(CMD_RADIX);          // zero number: radix sixteen
        add_text("7f");
        plan_add(CMD_COLOUR);
        add_text("9");
        plan_add(CH_LA + 8'(L_D));
        add_text("3");
        plan_add(CH_LZ);
        plan_add(CMD_RECT);
        plan_add(CMD_CIRCLE);
        plan_add(CMD_POINT);
        plan_add(CMD_POLY);
        plan_add(CMD_TEXT);
        plan_add(CMD_QUERY);
        add_text("5");
        plan_add(CMD_SERIES);
        plan_add(CMD_GRAPH);
        // open, char, close, escaped quote, restart, char, close
        plan_add(QUOTE_BYTE);
        add_text("a");
        plan_add(QUOTE_BYTE);
        plan_add(QUOTE_BYTE);
        plan_add(QUOTE_BYTE);
        add_text("x");
        plan_add(QUOTE_BYTE);
        plan_add(CMD_CLEAR);
        send_plan();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    squeeze_req     = 1'b1;
                end
                1:
                begin
                    sender_idle_pct = 86;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 86;
                end
                default:
                begin
                    sender_idle_pct = 34;
                    recv_stall_pct  = 34;
                end
            endcase
            add_random_bytes(PHASE_BYTES);
            send_plan();
        end
        s_axis_tvalid <= 1'b0;

        // let the checker take in the last transfer before polling
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && events_pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[files.f]
sv/scbp_pkg.sv
sv/scbp_attr_regs.sv
sv/scbp_decoder.sv
sv/shape_command_byte_parser_unit.sv
sim/scbp_event_checker.sv
sim/tb_top.sv
